// ----- rtl/dcf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types, constants and tables of the time code decoder.
// ----------------------------------------------------------------------------
package dcf_pkg;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_TICKS_PER_SECOND = 3'd0,
		REG_ZERO_TICKS       = 3'd1,
		REG_ONE_TICKS        = 3'd2,
		REG_TICK_TOLERANCE   = 3'd3,
		REG_INVERT_INPUT     = 3'd4
	} cfg_reg_e;

	localparam logic [6:0] RST_TICKS_PER_SECOND = 7'd64;
	localparam logic [5:0] RST_ZERO_TICKS       = 6'd6;
	localparam logic [5:0] RST_ONE_TICKS        = 6'd12;
	localparam logic [3:0] RST_TICK_TOLERANCE   = 4'd1;

	localparam logic [7:0] TICK_MAX      = 8'hFF;
	localparam logic [5:0] FIRST_SECOND  = 6'd21;
	localparam logic [5:0] LAST_SECOND   = 6'd58;
	localparam logic [5:0] MINUTE_END    = 6'd59;
	localparam logic [5:0] SECOND_LIMIT  = 6'd60;

	localparam logic [3:0] ERR_NO_SIGNAL = 4'b0001;
	localparam logic [3:0] ERR_PARITY    = 4'b0010;
	localparam logic [3:0] ERR_PULSE     = 4'b0100;
	localparam logic [3:0] ERR_PERIOD    = 4'b1000;

	localparam int unsigned FIELD_COUNT = 6;

	// field slots: minute, hour, weekday, day, month, year
	localparam logic [2:0] FLD_MINUTE  = 3'd0;
	localparam logic [2:0] FLD_HOUR    = 3'd1;
	localparam logic [2:0] FLD_WEEKDAY = 3'd2;
	localparam logic [2:0] FLD_DAY     = 3'd3;
	localparam logic [2:0] FLD_MONTH   = 3'd4;
	localparam logic [2:0] FLD_YEAR    = 3'd5;

	typedef struct packed {
		logic [6:0] ticks_per_second;
		logic [5:0] zero_ticks;
		logic [5:0] one_ticks;
		logic [3:0] tick_tolerance;
		logic       invert_input;
	} cfg_t;

	typedef struct packed {
		logic       time_valid;
		logic [3:0] error_flags;
		logic [6:0] minute_value;
		logic [5:0] hour_value;
		logic [2:0] weekday_value;
		logic [5:0] day_value;
		logic [4:0] month_value;
		logic [7:0] year_value;
	} result_t;

	// window hits for the current tick count
	typedef struct packed {
		logic zero_hit;
		logic one_hit;
		logic mark_hit;
		logic period_bad;
	} win_t;

	// what one tick does to the frame state
	typedef struct packed {
		logic no_signal;
		logic rising;
		logic falling;
		win_t win;
	} event_t;

	typedef struct packed {
		logic       parity;
		logic [2:0] field;
		logic [2:0] weight;
	} slot_t;

	// bit position within the time code (second minus 21) to its slot
	function automatic slot_t slot_of(input logic [5:0] pos);
		slot_t s;
		s = '0;
		priority if (pos <= 6'd6) begin
			s.field  = FLD_MINUTE;
			s.weight = pos[2:0];
		end else if (pos == 6'd7) begin
			s.parity = 1'b1;
		end else if (pos <= 6'd13) begin
			s.field  = FLD_HOUR;
			s.weight = 3'(pos - 6'd8);
		end else if (pos == 6'd14) begin
			s.parity = 1'b1;
		end else if (pos <= 6'd20) begin
			s.field  = FLD_DAY;
			s.weight = 3'(pos - 6'd15);
		end else if (pos <= 6'd23) begin
			s.field  = FLD_WEEKDAY;
			s.weight = 3'(pos - 6'd21);
		end else if (pos <= 6'd28) begin
			s.field  = FLD_MONTH;
			s.weight = 3'(pos - 6'd24);
		end else if (pos <= 6'd36) begin
			s.field  = FLD_YEAR;
			s.weight = 3'(pos - 6'd29);
		end else begin
			s.parity = 1'b1;
		end
		return s;
	endfunction

	// bcd style weights 1 2 4 8 10 20 40 80
	function automatic logic [7:0] weight_of(input logic [2:0] w);
		logic [7:0] r;
		unique case (w)
			3'd0: r = 8'd1;
			3'd1: r = 8'd2;
			3'd2: r = 8'd4;
			3'd3: r = 8'd8;
			3'd4: r = 8'd10;
			3'd5: r = 8'd20;
			3'd6: r = 8'd40;
			3'd7: r = 8'd80;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/dcf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf interfaces
// Valid/ready channels for tick samples, decoded results and register writes.
// ----------------------------------------------------------------------------
interface dcf_tick_if;
	logic valid;
	logic ready;
	logic level;
	modport source (output valid, output level, input ready);
	modport sink (input valid, input level, output ready);
endinterface

interface dcf_result_if;
	logic             valid;
	logic             ready;
	dcf_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dcf_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [6:0] value;
	modport source (output valid, output index, output value, input ready);
	modport sink (input valid, input index, input value, output ready);
endinterface

// ----- rtl/dcf_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_window
// Compares a tick count against the pulse and period windows.
// ----------------------------------------------------------------------------
module dcf_window (
	input  logic [7:0]    count,
	input  dcf_pkg::cfg_t cfg,
	output dcf_pkg::win_t win
);
	import dcf_pkg::*;

	typedef logic signed [10:0] sval_t;

	sval_t p, t, e, z, o;

	always_comb begin
		p = sval_t'({3'b000, count});
		t = sval_t'({4'b0000, cfg.ticks_per_second});
		e = sval_t'({7'b0000000, cfg.tick_tolerance});
		z = sval_t'({5'b00000, cfg.zero_ticks});
		o = sval_t'({5'b00000, cfg.one_ticks});

		win.zero_hit   = (p >= z - e) && (p <= z + e);
		win.one_hit    = (p >= o - e) && (p <= o + e);
		// two second gap before the minute mark
		win.mark_hit   = (p >= (t <<< 1) - (e <<< 1)) && (p <= (t <<< 1) + e);
		win.period_bad = (p < t - e - sval_t'(1)) || (p > t + e);
	end

endmodule

// ----- rtl/dcf_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_frame
// Second counter, parity and error tracking, field assembly and held time.
// ----------------------------------------------------------------------------
module dcf_frame (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  dcf_pkg::event_t  ev,
	output dcf_pkg::result_t res
);
	import dcf_pkg::*;

	logic [5:0] sidx_q, sidx_n, sidx_inc;
	logic       par_q, par_n, par_x;
	logic [3:0] err_q, err_n, err_ns;
	logic [7:0] asm_q [FIELD_COUNT];
	logic [7:0] asm_n [FIELD_COUNT];
	logic [7:0] held_q [FIELD_COUNT];
	logic [7:0] held_n [FIELD_COUNT];
	logic [7:0] base;
	logic       take, b, copy;
	slot_t      slot;

	always_comb begin
		err_ns = err_q | (ev.no_signal ? ERR_NO_SIGNAL : 4'b0000);
		err_n  = err_ns;
		sidx_n = sidx_q;
		par_n  = par_q;
		asm_n  = asm_q;
		held_n = held_q;
		copy   = 1'b0;
		take   = 1'b0;
		b      = ev.win.one_hit && !ev.win.zero_hit;
		slot   = slot_of(6'(sidx_q - FIRST_SECOND));
		par_x  = par_q ^ b;
		base   = (slot.weight == 3'd0) ? 8'd0 : asm_q[slot.field];
		sidx_inc = (sidx_q < SECOND_LIMIT) ? sidx_q + 6'd1 : sidx_q;

		if (ev.falling) begin
			if (ev.win.zero_hit || ev.win.one_hit) begin
				take = (sidx_q >= FIRST_SECOND) && (sidx_q <= LAST_SECOND);
			end else begin
				err_n = err_ns | ERR_PULSE;
			end
		end

		if (take) begin
			if (slot.parity) begin
				if (par_x) err_n = err_ns | ERR_PARITY;
				par_n = 1'b0;
			end else begin
				par_n = par_x;
				for (int k = 0; k < FIELD_COUNT; k++) begin
					if (3'(k) == slot.field) begin
						asm_n[k] = base + (b ? weight_of(slot.weight) : 8'd0);
					end
				end
			end
		end

		if (ev.rising) begin
			if (ev.win.mark_hit) begin
				copy   = (err_ns == 4'b0000) && (sidx_inc == MINUTE_END);
				if (copy) held_n = asm_q;
				sidx_n = '0;
				err_n  = '0;
			end else begin
				sidx_n = sidx_inc;
				if (ev.win.period_bad) err_n = err_ns | ERR_PERIOD;
			end
		end

		res.time_valid    = copy;
		res.error_flags   = err_ns;
		res.minute_value  = held_n[FLD_MINUTE][6:0];
		res.hour_value    = held_n[FLD_HOUR][5:0];
		res.weekday_value = held_n[FLD_WEEKDAY][2:0];
		res.day_value     = held_n[FLD_DAY][5:0];
		res.month_value   = held_n[FLD_MONTH][4:0];
		res.year_value    = held_n[FLD_YEAR];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sidx_q <= '0;
			par_q  <= 1'b0;
			err_q  <= '0;
			for (int k = 0; k < FIELD_COUNT; k++) begin
				asm_q[k]  <= '0;
				held_q[k] <= '0;
			end
		end else if (step) begin
			sidx_q <= sidx_n;
			par_q  <= par_n;
			err_q  <= err_n;
			asm_q  <= asm_n;
			held_q <= held_n;
		end
	end

endmodule

// ----- rtl/dcf77_time_code_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf77_time_code_decoder
// Decodes the minute time code from one sampled receiver level per tick.
// ----------------------------------------------------------------------------
// One level sample is taken per beat on the tick channel; it lands in an
// input register and is processed from there when it advances (edge detect,
// pulse and period window compare, bit accumulation), so a new tick can be
// accepted every cycle unless a stall holds it. Only a minute mark produces
// a result beat; it goes into the output register as its tick advances.
// Tick ready drops only while a minute-mark tick waits in the input register
// behind a result beat that the sink has not yet taken. Register writes are
// always accepted and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module dcf77_time_code_decoder (
	input logic          clk,
	input logic          arst_n,
	dcf_tick_if.sink     tick,
	dcf_result_if.source result,
	dcf_cfg_if.sink      cfg
);
	import dcf_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// input register
	logic s1_valid_q;
	logic s1_level_q;

	// tick counter and edge detector state
	logic [7:0] tick_count_q;
	logic [7:0] tick_inc;
	logic       last_level_q;
	logic       lvl;
	logic       edge_seen;

	// output register
	logic    out_valid_q;
	result_t out_data_q;

	logic    adv;
	logic    mark;
	logic    out_free;
	win_t    win;
	event_t  ev;
	result_t res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second <= RST_TICKS_PER_SECOND;
			cfg_q.zero_ticks       <= RST_ZERO_TICKS;
			cfg_q.one_ticks        <= RST_ONE_TICKS;
			cfg_q.tick_tolerance   <= RST_TICK_TOLERANCE;
			cfg_q.invert_input     <= 1'b0;
		end else if (cfg.valid) begin
			// writes beyond the register list are dropped
			unique case (cfg.index)
				REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg.value;
				REG_ZERO_TICKS:       cfg_q.zero_ticks       <= cfg.value[5:0];
				REG_ONE_TICKS:        cfg_q.one_ticks        <= cfg.value[5:0];
				REG_TICK_TOLERANCE:   cfg_q.tick_tolerance   <= cfg.value[3:0];
				REG_INVERT_INPUT:     cfg_q.invert_input     <= cfg.value[0];
				default: ;
			endcase
		end
	end

	// tick count saturates, the saturated state flags a lost signal
	assign tick_inc  = (tick_count_q == TICK_MAX) ? TICK_MAX : tick_count_q + 8'd1;
	assign lvl       = s1_level_q ^ cfg_q.invert_input;
	assign edge_seen = lvl != last_level_q;

	dcf_window u_window (
		.count (tick_inc),
		.cfg   (cfg_q),
		.win   (win)
	);

	always_comb begin
		ev.no_signal = tick_count_q == TICK_MAX;
		ev.rising    = edge_seen && lvl;
		ev.falling   = edge_seen && !lvl;
		ev.win       = win;
	end

	// a minute mark needs room in the output register
	assign mark     = s1_valid_q && ev.rising && win.mark_hit;
	assign out_free = !out_valid_q || result.ready;
	assign adv      = s1_valid_q && (!mark || out_free);

	assign tick.ready = !s1_valid_q || adv;

	dcf_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.ev     (ev),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			tick_count_q <= '0;
			last_level_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (tick.ready) s1_valid_q <= tick.valid;
			if (adv) begin
				last_level_q <= lvl;
				tick_count_q <= ev.rising ? 8'd0 : tick_inc;
			end
			if (adv && mark) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) s1_level_q <= tick.level;
		if (adv && mark) out_data_q <= res;
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// a good minute never carries an error flag
	a_valid_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.time_valid |-> result.data.error_flags == 4'b0000)
		else $error("time_valid set with error flags");

	// the input side stalls only behind a pending result beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tick.ready |-> s1_valid_q && out_valid_q && mark)
		else $error("tick stalled without a blocked minute mark");

	// a saturated counter stays saturated until an edge
	a_tick_sat: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tick_count_q == TICK_MAX && !edge_seen |=> tick_count_q == TICK_MAX)
		else $error("tick counter left saturation without an edge");

endmodule
